// ===== hw/rtl/fdrf_pkg.sv =====
// Package: shared types and constants of the frame delta dirty region finder.
`timescale 1ns / 1ps

package fdrf_pkg;

  localparam int MaxSamples  = 4096;
  localparam int RegionSlots = 16;
  localparam int PosW        = $clog2(MaxSamples + 1);
  localparam int AddrW       = $clog2(MaxSamples);
  localparam int SlotW       = $clog2(RegionSlots);
  localparam int CntW        = $clog2(RegionSlots + 1);
  localparam int RgnDepth    = 2 * RegionSlots;
  localparam int TolW        = 31;
  localparam int MaxRegW     = 5;
  localparam int CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_REGIONS = 1'b1;

  localparam logic [MaxRegW-1:0] MAX_REGIONS_RST = 5'd10;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic        full_upload;
    logic        region_valid;
    logic [11:0] region_start;
    logic [12:0] region_end;
    logic [4:0]  region_total;
    logic [12:0] dirty_samples;
    logic        final_result;
  } out_word_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [PosW-1:0]  finish;
  } region_t;

  typedef enum logic {
    EM_IDLE,
    EM_EMIT
  } em_state_t;

endpackage

// ===== hw/rtl/frame_delta_dirty_region_finder.sv =====
// Top level: frame delta dirty region finder with sample store and region report.
`timescale 1ns / 1ps

//  channel | direction | handshake           | word
//  in_     | input     | in_valid / in_stall   | fdrf_pkg::in_word_t
//  out_    | output    | out_valid / out_stall | fdrf_pkg::out_word_t
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
//  One sample a cycle while in_stall is low: the store is read on acceptance into a register and
//  the sample is compared and written back from the compare stage. A frame's report is loaded
//  when its last sample is compared and gives one word a cycle while out_stall is low: a single
//  word for a full upload or a clean frame, else one word per region. An end-of-frame sample
//  stalls input while the previous report of up to RegionSlots words is sent or held by out_stall.
//  No clearing pass after reset.
module frame_delta_dirty_region_finder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fdrf_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fdrf_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [fdrf_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [fdrf_pkg::TolW-1:0]         cfg_wdata
);

  localparam int PosW     = fdrf_pkg::PosW;
  localparam int AddrW    = fdrf_pkg::AddrW;
  localparam int SlotW    = fdrf_pkg::SlotW;
  localparam int CntW     = fdrf_pkg::CntW;

  // configuration
  logic [fdrf_pkg::TolW-1:0]    tol_r;
  logic [fdrf_pkg::MaxRegW-1:0] max_regions_r;

  // memories
  logic [31:0]       frame_mem [fdrf_pkg::MaxSamples];
  logic [31:0]       frame_rd_r;
  fdrf_pkg::region_t rgn_mem [fdrf_pkg::RgnDepth];
  fdrf_pkg::region_t rgn_rd_r;

  // input side
  logic             in_acc;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic             pos_ovf;

  // compare stage
  logic               s1_valid_r, s1_valid_nxt;
  logic signed [31:0] s1_sample_r;
  logic               s1_eof_r;
  logic [PosW-1:0]    s1_idx_r;
  logic               s1_ovf_r;
  logic               byp_r;
  logic [31:0]        byp_data_r;
  logic               s1_go;

  logic [31:0]        prev_val;
  logic signed [32:0] diff_w, tol_pos, tol_neg;
  logic               cmp_en, changed;
  logic [PosW-1:0]    length_w;

  // frame state
  logic             prev_valid_r, prev_valid_nxt;
  logic [PosW-1:0]  prev_length_r, prev_length_nxt;
  logic             inside_r, inside_nxt;
  logic [AddrW-1:0] open_start_r, open_start_nxt;
  logic [CntW-1:0]  regions_r, regions_nxt;
  logic             too_many_r, too_many_nxt;
  logic [PosW-1:0]  changed_cnt_r, changed_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;

  logic              add_en, add_room;
  fdrf_pkg::region_t add_rec;
  logic              ovf_fin, too_many_fin;
  logic [CntW-1:0]   regions_fin;
  logic [PosW-1:0]   cnt_fin;
  logic              em_load;

  // report
  fdrf_pkg::em_state_t em_state_r, em_state_nxt;
  logic              em_bad_r;
  logic [CntW-1:0]   em_regions_r;
  logic [PosW-1:0]   em_changed_r;
  logic [PosW-1:0]   em_half_r;
  logic              em_bank_r;
  logic [SlotW-1:0]  em_k_r;
  logic              em_fire, em_last, em_full, em_rd;
  fdrf_pkg::out_word_t out_ctl_r, out_ctl_nxt;
  logic              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r         <= '0;
      max_regions_r <= fdrf_pkg::MAX_REGIONS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fdrf_pkg::CFG_TOLERANCE:   tol_r         <= cfg_wdata;
        fdrf_pkg::CFG_MAX_REGIONS: max_regions_r <= cfg_wdata[fdrf_pkg::MaxRegW-1:0];
        default: ;
      endcase
    end
  end

  // input side and store read
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;
  assign pos_ovf  = (pos_r >= PosW'(fdrf_pkg::MaxSamples));

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      if (in_word.end_of_frame) begin
        pos_nxt = '0;
      end else if (!pos_ovf) begin
        pos_nxt = pos_r + PosW'(1);
      end
    end
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_ovf_r) begin
      frame_mem[s1_idx_r[AddrW-1:0]] <= s1_sample_r;
    end
    if (in_acc && !pos_ovf) begin
      frame_rd_r <= frame_mem[pos_r[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_word.sample;
      s1_eof_r    <= in_word.end_of_frame;
      s1_idx_r    <= pos_r;
      s1_ovf_r    <= pos_ovf;
      byp_r       <= s1_go && !s1_ovf_r && (s1_idx_r == pos_r);
      byp_data_r  <= s1_sample_r;
    end
  end

  // compare
  assign s1_go    = s1_valid_r && (!s1_eof_r || (em_state_r == fdrf_pkg::EM_IDLE));
  assign prev_val = byp_r ? byp_data_r : frame_rd_r;
  assign diff_w   = $signed({s1_sample_r[31], s1_sample_r}) - $signed({prev_val[31], prev_val});
  assign tol_pos  = $signed({2'b00, tol_r});
  assign tol_neg  = -tol_pos;
  assign cmp_en   = prev_valid_r && !s1_ovf_r && (s1_idx_r < prev_length_r);
  assign changed  = cmp_en && ((diff_w > tol_pos) || (diff_w < tol_neg));
  assign length_w = s1_ovf_r ? PosW'(fdrf_pkg::MaxSamples) : s1_idx_r + PosW'(1);

  always_comb begin
    inside_nxt      = inside_r;
    open_start_nxt  = open_start_r;
    changed_cnt_nxt = changed_cnt_r;
    ovf_nxt         = ovf_r;
    prev_valid_nxt  = prev_valid_r;
    prev_length_nxt = prev_length_r;
    bank_nxt        = bank_r;
    add_en          = 1'b0;
    add_rec.start   = open_start_r;
    add_rec.finish  = s1_idx_r;
    em_load         = 1'b0;

    if (s1_ovf_r) begin
      ovf_nxt = 1'b1;
    end else if (changed) begin
      changed_cnt_nxt = changed_cnt_r + PosW'(1);
      if (!inside_r) begin
        inside_nxt     = 1'b1;
        open_start_nxt = s1_idx_r[AddrW-1:0];
      end
    end else if (inside_r) begin
      add_en     = 1'b1;
      inside_nxt = 1'b0;
    end

    if (s1_eof_r && inside_nxt) begin
      add_en         = 1'b1;
      add_rec.start  = open_start_nxt;
      add_rec.finish = length_w;
    end

    add_room     = (regions_r < CntW'(fdrf_pkg::RegionSlots));
    regions_fin  = (add_en && add_room) ? regions_r + CntW'(1) : regions_r;
    too_many_fin = too_many_r || (add_en && !add_room);
    ovf_fin      = ovf_nxt;
    cnt_fin      = changed_cnt_nxt;
    regions_nxt  = regions_fin;
    too_many_nxt = too_many_fin;

    if (s1_eof_r) begin
      em_load         = s1_go;
      prev_valid_nxt  = !ovf_fin;
      prev_length_nxt = ovf_fin ? '0 : length_w;
      bank_nxt        = !bank_r;
      inside_nxt      = 1'b0;
      open_start_nxt  = '0;
      regions_nxt     = '0;
      too_many_nxt    = 1'b0;
      changed_cnt_nxt = '0;
      ovf_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && add_en && add_room) begin
      rgn_mem[{bank_r, regions_r[SlotW-1:0]}] <= add_rec;
    end
    if (em_rd) begin
      rgn_rd_r <= rgn_mem[{em_bank_r, em_k_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) begin
      em_bad_r     <= !prev_valid_r || ovf_fin || (length_w != prev_length_r) || too_many_fin;
      em_regions_r <= regions_fin;
      em_changed_r <= cnt_fin;
      em_half_r    <= length_w >> 1;
      em_bank_r    <= bank_r;
    end
  end

  // report sequencer
  assign em_full = em_bad_r || (em_regions_r > CntW'(max_regions_r)) || (em_changed_r > em_half_r);

  always_comb begin
    em_state_nxt = em_state_r;
    case (em_state_r)
      fdrf_pkg::EM_IDLE: begin
        if (em_load) begin
          em_state_nxt = fdrf_pkg::EM_EMIT;
        end
      end
      fdrf_pkg::EM_EMIT: begin
        if (em_fire && em_last) begin
          em_state_nxt = fdrf_pkg::EM_IDLE;
        end
      end
      default: em_state_nxt = fdrf_pkg::EM_IDLE;
    endcase
  end

  always_comb begin
    em_fire     = (em_state_r == fdrf_pkg::EM_EMIT) && (!out_valid_r || !out_stall);
    em_last     = em_full || (em_regions_r == '0) ||
                  ((CntW'(em_k_r) + CntW'(1)) == em_regions_r);
    em_rd       = em_fire && !em_full && (em_regions_r != '0);
    out_ctl_nxt = '0;
    if (em_full) begin
      out_ctl_nxt.full_upload  = 1'b1;
      out_ctl_nxt.final_result = 1'b1;
    end else begin
      out_ctl_nxt.region_valid  = (em_regions_r != '0);
      out_ctl_nxt.region_total  = 5'(em_regions_r);
      out_ctl_nxt.dirty_samples = 13'(em_changed_r);
      out_ctl_nxt.final_result  = em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) begin
      em_k_r <= '0;
    end else if (em_fire) begin
      em_k_r <= em_k_r + SlotW'(1);
    end
    if (em_fire) begin
      out_ctl_r <= out_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      s1_valid_r    <= 1'b0;
      prev_valid_r  <= 1'b0;
      prev_length_r <= '0;
      inside_r      <= 1'b0;
      open_start_r  <= '0;
      regions_r     <= '0;
      too_many_r    <= 1'b0;
      changed_cnt_r <= '0;
      ovf_r         <= 1'b0;
      bank_r        <= 1'b0;
      em_state_r    <= fdrf_pkg::EM_IDLE;
      out_valid_r   <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        prev_valid_r  <= prev_valid_nxt;
        prev_length_r <= prev_length_nxt;
        inside_r      <= inside_nxt;
        open_start_r  <= open_start_nxt;
        regions_r     <= regions_nxt;
        too_many_r    <= too_many_nxt;
        changed_cnt_r <= changed_cnt_nxt;
        ovf_r         <= ovf_nxt;
        bank_r        <= bank_nxt;
      end
      em_state_r <= em_state_nxt;
      if (em_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // assemble the result word
  always_comb begin
    out_word = out_ctl_r;
    out_word.region_start = out_ctl_r.region_valid ? 12'(rgn_rd_r.start)  : '0;
    out_word.region_end   = out_ctl_r.region_valid ? 13'(rgn_rd_r.finish) : '0;
  end
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_full_is_final : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.full_upload |-> out_word.final_result && !out_word.region_valid)
    else $error("full upload word not marked final");

  a_stall_only_eof : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_eof_r && (em_state_r == fdrf_pkg::EM_EMIT))
    else $error("input stalled without a waiting end of frame");

  a_load_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    em_load |-> (em_state_r == fdrf_pkg::EM_IDLE))
    else $error("report loaded while previous report in progress");

  a_region_count : assert property (@(posedge clk) disable iff (!rst_n)
    regions_r <= CntW'(fdrf_pkg::RegionSlots))
    else $error("region count beyond slots");
`endif

endmodule

// ===== dv/tb.sv =====
// Testbench: streams frames into the dirty region finder and checks every report word.
`timescale 1ns / 1ps
module tb;

  localparam int          LIMIT = 600_000;
  localparam logic [31:0] MSB   = 32'h8000_0000;
  localparam fdrf_pkg::out_word_t FULL_REPORT  = {1'b1, 1'b0, 12'd0, 13'd0, 5'd0, 13'd0, 1'b1};
  localparam fdrf_pkg::out_word_t CLEAN_REPORT = {1'b0, 1'b0, 12'd0, 13'd0, 5'd0, 13'd0, 1'b1};

  typedef struct {
    fdrf_pkg::in_word_t  w;
    bit                  typed;
    fdrf_pkg::out_word_t want;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  fdrf_pkg::in_word_t            in_word;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  fdrf_pkg::out_word_t           out_word;
  logic                          cfg_we;
  logic [fdrf_pkg::CfgIdxW-1:0]  cfg_index;
  logic [fdrf_pkg::TolW-1:0]     cfg_wdata;

  // frame history and region tracking as the block should hold them
  logic [31:0]                   store [fdrf_pkg::MaxSamples];
  bit                            prev_valid = 1'b0;
  int                            prev_len = 0;
  int                            pos = 0;
  bit                            in_rgn = 1'b0;
  int                            open_s = 0;
  int                            rgn_b [fdrf_pkg::RegionSlots];
  int                            rgn_f [fdrf_pkg::RegionSlots];
  int                            rgn_cnt = 0;
  bit                            rgn_spill = 1'b0;
  int                            chg_cnt = 0;
  bit                            spill = 1'b0;
  logic [fdrf_pkg::TolW-1:0]     tol = '0;
  logic [fdrf_pkg::MaxRegW-1:0]  max_rgn = fdrf_pkg::MAX_REGIONS_RST;

  fdrf_pkg::out_word_t           pending_reports [$];
  fdrf_pkg::out_word_t           fresh_reports [$];
  fdrf_pkg::in_word_t            frame_buf [$];
  row_t                          dir_rows [$];

  bit                  calm = 1'b0;
  int                  hold_cnt = 0;
  int                  faults = 0;
  int                  cycles = 0;
  int                  n_frames = 0;
  int                  n_samples = 0;
  int                  n_words = 0;
  int                  n_region_words = 0;
  int                  n_full = 0;
  int                  n_clean = 0;
  int                  n_writes = 0;

  frame_delta_dirty_region_finder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timed out after %0d cycles with %0d report words pending.", cycles,
               pending_reports.size());
      $display("** frame_delta_dirty_region_finder: FAILED **");
      $finish;
    end
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic fdrf_pkg::out_word_t make_word(bit full, bit valid, int s, int e, int tot,
                                                    int dirty, bit fin);
    fdrf_pkg::out_word_t r;
    r.full_upload   = full;
    r.region_valid  = valid;
    r.region_start  = s[11:0];
    r.region_end    = e[12:0];
    r.region_total  = tot[4:0];
    r.dirty_samples = dirty[12:0];
    r.final_result  = fin;
    return r;
  endfunction

  task automatic close_region(input int s, input int e);
    if (rgn_cnt < fdrf_pkg::RegionSlots) begin
      rgn_b[rgn_cnt] = s;
      rgn_f[rgn_cnt] = e;
      rgn_cnt++;
    end else begin
      rgn_spill = 1'b1;
    end
  endtask

  task automatic absorb_sample(input fdrf_pkg::in_word_t w);
    longint a;
    longint b;
    longint d;
    bit     hit;
    bit     full;
    int     k;
    fresh_reports.delete();
    if (pos >= fdrf_pkg::MaxSamples) begin
      spill = 1'b1;
    end else begin
      hit = 1'b0;
      if (prev_valid && pos < prev_len) begin
        a = $signed(w.sample);
        b = $signed(store[pos]);
        d = a - b;
        if (d < 0) d = -d;
        hit = d > longint'(tol);
      end
      if (hit) begin
        chg_cnt++;
        if (!in_rgn) begin
          in_rgn = 1'b1;
          open_s = pos;
        end
      end else if (in_rgn) begin
        close_region(open_s, pos);
        in_rgn = 1'b0;
      end
      store[pos] = w.sample;
      pos++;
    end
    if (w.end_of_frame) begin
      if (in_rgn) close_region(open_s, pos);
      full = !prev_valid || spill || pos != prev_len || rgn_spill ||
             rgn_cnt > int'(max_rgn) || chg_cnt > pos / 2;
      if (full) begin
        fresh_reports = {fresh_reports, FULL_REPORT};
      end else if (rgn_cnt == 0) begin
        fresh_reports = {fresh_reports, make_word(1'b0, 1'b0, 0, 0, 0, chg_cnt, 1'b1)};
      end else begin
        for (k = 0; k < rgn_cnt; k++)
          fresh_reports = {fresh_reports, make_word(1'b0, 1'b1, rgn_b[k], rgn_f[k], rgn_cnt,
                                                    chg_cnt, k == rgn_cnt - 1)};
      end
      prev_valid = !spill;
      prev_len   = spill ? 0 : pos;
      pos        = 0;
      in_rgn     = 1'b0;
      open_s     = 0;
      rgn_cnt    = 0;
      rgn_spill  = 1'b0;
      chg_cnt    = 0;
      spill      = 1'b0;
    end
  endtask

  task automatic push_word(input fdrf_pkg::in_word_t w);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed(input fdrf_pkg::in_word_t w, input bit typed,
                      input fdrf_pkg::out_word_t want);
    push_word(w);
    absorb_sample(w);
    n_samples++;
    if (w.end_of_frame) n_frames++;
    if (typed && w.end_of_frame) begin
      pending_reports = {pending_reports, want};
    end else begin
      foreach (fresh_reports[k]) pending_reports = {pending_reports, fresh_reports[k]};
    end
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) feed(frame_buf[i], 1'b0, '0);
  endtask

  task automatic add_row(input logic [31:0] s, input bit eof, input bit typed,
                         input fdrf_pkg::out_word_t want);
    row_t r;
    r.w.sample       = s;
    r.w.end_of_frame = eof;
    r.typed          = typed;
    r.want           = want;
    dir_rows = {dir_rows, r};
  endtask

  task automatic write_regs(input logic [fdrf_pkg::TolW-1:0] tol_v,
                            input logic [fdrf_pkg::MaxRegW-1:0] max_v);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= fdrf_pkg::CFG_TOLERANCE;
    cfg_wdata <= tol_v;
    @(posedge clk);
    tol = tol_v;
    cfg_index <= fdrf_pkg::CFG_MAX_REGIONS;
    cfg_wdata <= {{(fdrf_pkg::TolW - fdrf_pkg::MaxRegW){1'b0}}, max_v};
    @(posedge clk);
    max_rgn = max_v;
    cfg_we  <= 1'b0;
    n_writes += 2;
  endtask

  task automatic copy_frame(input int len);
    fdrf_pkg::in_word_t w;
    int                 i;
    frame_buf.delete();
    for (i = 0; i < len; i++) begin
      w.sample       = (prev_valid && i < prev_len) ? store[i] : $urandom;
      w.end_of_frame = (i == len - 1);
      frame_buf = {frame_buf, w};
    end
  endtask

  task automatic flip(input int idx);
    fdrf_pkg::in_word_t w;
    w = frame_buf[idx];
    w.sample = w.sample ^ MSB;
    frame_buf[idx] = w;
  endtask

  function automatic logic [31:0] nudge(input logic [31:0] base, input bit change);
    logic [31:0] t;
    t = {1'b0, tol};
    if (change) begin
      case ($urandom_range(0, 3))
        0: return base ^ MSB;
        1: return base + t + 32'd1;
        2: return base - t - 32'd1;
        default: return $urandom;
      endcase
    end
    case ($urandom_range(0, 3))
      2: return base + t;
      3: return base - $urandom_range(0, t);
      default: return base;
    endcase
  endfunction

  task automatic build_random_frame();
    fdrf_pkg::in_word_t w;
    int                 len;
    int                 p_start;
    int                 i;
    bit                 noise;
    bit                 dirty;
    logic [31:0]        base;
    frame_buf.delete();
    noise = ($urandom_range(0, 9) == 0);
    if (!noise && prev_valid && prev_len != 0 && prev_len <= 64 &&
        $urandom_range(0, 4) != 0)
      len = prev_len;
    else
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 48);
    p_start = $urandom_range(0, 30);
    dirty   = 1'b0;
    for (i = 0; i < len; i++) begin
      base = (prev_valid && i < prev_len) ? store[i] : $urandom;
      if (dirty) dirty = ($urandom_range(0, 2) != 0);
      else dirty = ($urandom_range(0, 99) < p_start);
      w.sample       = noise ? $urandom : nudge(base, dirty);
      w.end_of_frame = (i == len - 1);
      frame_buf = {frame_buf, w};
    end
  endtask

  task automatic match(input string fld, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fld, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin : watch_reports
    fdrf_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report word %h arrived with nothing pending", out_word);
        faults++;
      end else begin
        want = pending_reports.pop_front();
        n_words++;
        if (want.full_upload) n_full++;
        else if (want.region_valid) n_region_words++;
        else n_clean++;
        match("full_upload", want.full_upload, out_word.full_upload);
        match("region_valid", want.region_valid, out_word.region_valid);
        match("region_start", want.region_start, out_word.region_start);
        match("region_end", want.region_end, out_word.region_end);
        match("region_total", want.region_total, out_word.region_total);
        match("dirty_samples", want.dirty_samples, out_word.dirty_samples);
        match("final_result", want.final_result, out_word.final_result);
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      hold_cnt  = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int                           ph;
    int                           k;
    int                           budget;
    logic [fdrf_pkg::TolW-1:0]    tol_v;
    logic [fdrf_pkg::MaxRegW-1:0] max_v;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= fdrf_pkg::CFG_TOLERANCE;
    cfg_wdata <= '0;

    // no history, identical, changed at the start, length change, changed at the end,
    // single sample, over half changed, single sample unchanged
    add_row(32'h0000_0000, 1'b0, 1'b0, '0);
    add_row(32'h7fff_ffff, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(32'hffff_ffff, 1'b1, 1'b1, FULL_REPORT);
    add_row(32'h0000_0000, 1'b0, 1'b0, '0);
    add_row(32'h7fff_ffff, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(32'hffff_ffff, 1'b1, 1'b1, CLEAN_REPORT);
    add_row(32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(32'hffff_ffff, 1'b1, 1'b0, '0);
    add_row(32'h0000_0001, 1'b0, 1'b0, '0);
    add_row(32'h0000_0002, 1'b0, 1'b0, '0);
    add_row(32'h0000_0003, 1'b1, 1'b1, FULL_REPORT);
    add_row(32'h0000_0001, 1'b0, 1'b0, '0);
    add_row(32'h0000_0002, 1'b0, 1'b0, '0);
    add_row(32'h0000_0009, 1'b1, 1'b0, '0);
    add_row(32'h0000_0005, 1'b1, 1'b1, FULL_REPORT);
    add_row(32'h0000_0006, 1'b1, 1'b1, FULL_REPORT);
    add_row(32'h0000_0006, 1'b1, 1'b1, CLEAN_REPORT);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) feed(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    in_valid <= 1'b0;

    // region count at and past the limits
    write_regs('0, 5'd16);
    copy_frame(40);
    send_frame();
    copy_frame(40);
    for (k = 0; k < 32; k += 2) flip(k);
    send_frame();
    copy_frame(40);
    for (k = 0; k <= 32; k += 2) flip(k);
    send_frame();
    in_valid <= 1'b0;
    write_regs('0, 5'd0);
    copy_frame(40);
    flip(5);
    send_frame();
    in_valid <= 1'b0;
    write_regs({fdrf_pkg::TolW{1'b1}}, 5'd1);
    copy_frame(40);
    flip(7);
    send_frame();
    in_valid <= 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      case ($urandom_range(0, 3))
        0: tol_v = '0;
        1: tol_v = fdrf_pkg::TolW'($urandom_range(1, 65536));
        2: tol_v = fdrf_pkg::TolW'($urandom);
        default: tol_v = fdrf_pkg::TolW'($urandom_range(0, 255));
      endcase
      if (ph == 0) tol_v = '0;
      if (ph == 3) tol_v = {fdrf_pkg::TolW{1'b1}};
      max_v = (ph == 1) ? 5'd16 : fdrf_pkg::MaxRegW'($urandom_range(4, 16));
      write_regs(tol_v, max_v);
      budget = 0;
      while (budget < 50) begin
        build_random_frame();
        budget += frame_buf.size();
        send_frame();
      end
      in_valid <= 1'b0;
    end

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Ran %0d frames of %0d samples with %0d register writes; %0d report words checked.",
             n_frames, n_samples, n_writes, n_words);
    $display("Reports held %0d region words, %0d full uploads and %0d clean frames.",
             n_region_words, n_full, n_clean);
    if (faults == 0) begin
      $display("** frame_delta_dirty_region_finder: PASSED **");
    end else begin
      $display("** frame_delta_dirty_region_finder: FAILED **");
    end
    $finish;
  end

endmodule
